// ----- src/efp_pkg.sv -----
// Shared types and constants for the electronic fuse protector core.
// Used by efp_cfg_regs, efp_fuse_step and electronic_fuse_protector_core.
`timescale 1ns / 1ps

package efp_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned VOLT_W      = 16;
    localparam int unsigned CURR_W      = 16;
    localparam int unsigned DT_W        = 10;
    localparam int unsigned AGE_W       = 16;

    localparam logic [AGE_W-1:0]  AGE_MAX          = {AGE_W{1'b1}};
    localparam logic [15:0]       RECOVERY_DEFAULT = 16'd3000;
    localparam logic [VOLT_W-1:0] OV_LIMIT_DEFAULT = {VOLT_W{1'b1}};
    localparam logic [CURR_W-1:0] OC_LIMIT_DEFAULT = {CURR_W{1'b1}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FORCE_OFF     = 3'd0,
        REG_OV_ENABLE     = 3'd1,
        REG_OV_LIMIT      = 3'd2,
        REG_OC_ENABLE     = 3'd3,
        REG_OC_LIMIT      = 3'd4,
        REG_AUTO_RECOVERY = 3'd5,
        REG_RECOVERY_MS   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic              force_off;
        logic              overvoltage_enable;
        logic [VOLT_W-1:0] overvoltage_limit_mv;
        logic              overcurrent_enable;
        logic [CURR_W-1:0] overcurrent_limit_ma;
        logic              auto_recovery_enable;
        logic [AGE_W-1:0]  recovery_ms;
    } cfg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic [CURR_W-1:0] current_ma;
        logic [DT_W-1:0]   elapsed_ms;
    } sample_t;

    typedef struct packed {
        logic             fault_latched;
        logic             switch_on;
        logic [AGE_W-1:0] latch_age_ms;
    } state_t;

    typedef struct packed {
        logic output_on;
        logic overvoltage_now;
        logic overcurrent_now;
        logic off_by_fault;
        logic switched_on;
        logic switched_off;
    } result_t;

endpackage

// ----- src/efp_cfg_regs.sv -----
// Configuration register file for the electronic fuse protector.
// Depends on efp_pkg for the register index codes and the cfg_t bundle.
`timescale 1ns / 1ps

module efp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [efp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [efp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output efp_pkg::cfg_t                    cfg
);

    efp_pkg::cfg_t cfg_reg;

    // Writes to an unlisted index are dropped; narrow registers keep bit zero only.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_off            <= 1'b0;
            cfg_reg.overvoltage_enable   <= 1'b0;
            cfg_reg.overvoltage_limit_mv <= efp_pkg::OV_LIMIT_DEFAULT;
            cfg_reg.overcurrent_enable   <= 1'b0;
            cfg_reg.overcurrent_limit_ma <= efp_pkg::OC_LIMIT_DEFAULT;
            cfg_reg.auto_recovery_enable <= 1'b0;
            cfg_reg.recovery_ms          <= efp_pkg::RECOVERY_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (efp_pkg::cfg_index_t'(cfg_index))
                efp_pkg::REG_FORCE_OFF:     cfg_reg.force_off            <= cfg_data[0];
                efp_pkg::REG_OV_ENABLE:     cfg_reg.overvoltage_enable   <= cfg_data[0];
                efp_pkg::REG_OV_LIMIT:      cfg_reg.overvoltage_limit_mv <= cfg_data;
                efp_pkg::REG_OC_ENABLE:     cfg_reg.overcurrent_enable   <= cfg_data[0];
                efp_pkg::REG_OC_LIMIT:      cfg_reg.overcurrent_limit_ma <= cfg_data;
                efp_pkg::REG_AUTO_RECOVERY: cfg_reg.auto_recovery_enable <= cfg_data[0];
                efp_pkg::REG_RECOVERY_MS:   cfg_reg.recovery_ms          <= cfg_data;
                default:                    cfg_reg                      <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/efp_fuse_step.sv -----
// Combinational fuse decision for one sample: limit compares, latch age update
// and recovery check. Depends on efp_pkg for the cfg_t, sample_t, state_t and result_t types.
`timescale 1ns / 1ps

module efp_fuse_step (
    input  efp_pkg::cfg_t    cfg,
    input  efp_pkg::sample_t sample,
    input  efp_pkg::state_t  state,
    output efp_pkg::state_t  state_next,
    output efp_pkg::result_t result
);

    logic [efp_pkg::AGE_W:0]   age_sum;
    logic [efp_pkg::AGE_W-1:0] age_aged;
    logic                      ov;
    logic                      oc;
    logic                      by_fault;

    // The age grows only while the latch is set, and sticks at full scale.
    assign age_sum  = {1'b0, state.latch_age_ms}
                    + {{(efp_pkg::AGE_W + 1 - efp_pkg::DT_W){1'b0}}, sample.elapsed_ms};
    assign age_aged = !state.fault_latched ? state.latch_age_ms
                    : (age_sum[efp_pkg::AGE_W] ? efp_pkg::AGE_MAX
                                               : age_sum[efp_pkg::AGE_W-1:0]);

    assign ov = cfg.overvoltage_enable && (sample.voltage_mv > cfg.overvoltage_limit_mv);
    assign oc = cfg.overcurrent_enable && (sample.current_ma > cfg.overcurrent_limit_ma);

    always_comb
    begin
        state_next.fault_latched = state.fault_latched;
        state_next.latch_age_ms  = age_aged;
        state_next.switch_on     = 1'b0;
        by_fault                 = 1'b0;
        priority if (cfg.force_off)
        begin
            state_next.switch_on = 1'b0;
        end
        else if (ov || oc)
        begin
            // Only the first fault restarts the age.
            if (!state.fault_latched)
            begin
                state_next.fault_latched = 1'b1;
                state_next.latch_age_ms  = '0;
            end
            by_fault = 1'b1;
        end
        else if (!state.fault_latched)
        begin
            state_next.switch_on = 1'b1;
        end
        else if (cfg.auto_recovery_enable && (age_aged >= cfg.recovery_ms))
        begin
            state_next.fault_latched = 1'b0;
            state_next.latch_age_ms  = '0;
            state_next.switch_on     = 1'b1;
        end
        else
        begin
            by_fault = 1'b1;
        end
    end

    assign result.output_on       = state_next.switch_on;
    assign result.overvoltage_now = ov && !cfg.force_off;
    assign result.overcurrent_now = oc && !cfg.force_off;
    assign result.off_by_fault    = by_fault;
    assign result.switched_on     = !state.switch_on && state_next.switch_on;
    assign result.switched_off    = state.switch_on && !state_next.switch_on;

endmodule

// ----- src/electronic_fuse_protector_core.sv -----
// Top level of the electronic fuse protector: input register, fuse state and result register.
// Depends on efp_pkg, efp_cfg_regs and efp_fuse_step.
`timescale 1ns / 1ps

// Usage
// Samples arrive on the input channel (in_valid / in_ready) as one word holding
// voltage_mv, current_ma and elapsed_ms. Each sample yields exactly one result word
// on the output channel (out_valid / out_ready) with the switch state and status flags.
// A sample is captured in the input register on acceptance; on the next edge at which
// the result register is free, the fuse decision is made, the fuse state is updated and
// the result is registered, raising out_valid. The block sustains one sample per clock
// cycle while the receiver takes each result; the rate is set by the update of the latch
// and latch age registers in the same cycle as the result register.
// When the receiver stalls, the result register holds its word and the input register
// holds the next sample, so two words are buffered before in_ready drops.
// Configuration is written through cfg_we, cfg_index and cfg_data, taking effect at once;
// it is meant to be written while no sample is in flight.
// Reset clears the valid flags of both pipeline stages, the fault latch, the latch age and the
// stored switch state, and loads every configuration register with its default value.

module electronic_fuse_protector_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [efp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [efp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [efp_pkg::VOLT_W-1:0]       voltage_mv,
    input  logic [efp_pkg::CURR_W-1:0]       current_ma,
    input  logic [efp_pkg::DT_W-1:0]         elapsed_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             output_on,
    output logic                             overvoltage_now,
    output logic                             overcurrent_now,
    output logic                             off_by_fault,
    output logic                             switched_on,
    output logic                             switched_off
);

    efp_pkg::cfg_t    cfg;
    efp_pkg::sample_t sample_reg;
    logic             sample_valid_reg;
    efp_pkg::state_t  state_reg;
    efp_pkg::state_t  state_next;
    efp_pkg::result_t result_reg;
    efp_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             result_load;

    efp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    efp_fuse_step u_fuse_step (
        .cfg        (cfg),
        .sample     (sample_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The held sample moves on whenever the result register is empty or being drained.
    assign result_load = sample_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready    = !sample_valid_reg || result_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                sample_valid_reg <= in_valid;
            end
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.voltage_mv <= voltage_mv;
            sample_reg.current_ma <= current_ma;
            sample_reg.elapsed_ms <= elapsed_ms;
        end
        if (result_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = result_valid_reg;
    assign output_on       = result_reg.output_on;
    assign overvoltage_now = result_reg.overvoltage_now;
    assign overcurrent_now = result_reg.overcurrent_now;
    assign off_by_fault    = result_reg.off_by_fault;
    assign switched_on     = result_reg.switched_on;
    assign switched_off    = result_reg.switched_off;

`ifndef SYNTHESIS
    // With the latch clear, the age must be back at zero.
    a_age_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.fault_latched |-> (state_reg.latch_age_ms == '0))
        else $error("latch age nonzero while latch is clear");

    // The reported switch state tracks the stored switch after each update.
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (output_on == state_reg.switch_on))
        else $error("result switch state differs from stored switch");

    // A fault-driven off never shows the switch on.
    a_fault_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(output_on && off_by_fault))
        else $error("output on while off by fault");

    // Forced off clears overvoltage_now, overcurrent_now, off_by_fault and output_on in the result it produces.
    a_force_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && cfg.force_off) |=>
            (!overvoltage_now && !overcurrent_now && !off_by_fault && !output_on))
        else $error("status flags set during forced off");

    // The input side never takes a sample while both stages are full and stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid_reg && result_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while pipeline is full");
`endif

endmodule
